>>> sv/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg
// Shared widths, command codes and datapath command/status types.
// ----------------------------------------------------------------------------
package mau_pkg;
	localparam int MOD_WIDTH = 31;
	localparam int CMD_WIDTH = 3;
	localparam int EXP_WIDTH = 64;
	localparam int EXP_CNT_WIDTH = $clog2(EXP_WIDTH + 1);
	localparam int BIT_CNT_WIDTH = $clog2(MOD_WIDTH + 1);
	localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(1000000007);

	localparam logic [CMD_WIDTH-1:0] CMD_ADD = 3'd0;
	localparam logic [CMD_WIDTH-1:0] CMD_SUB = 3'd1;
	localparam logic [CMD_WIDTH-1:0] CMD_MUL = 3'd2;
	localparam logic [CMD_WIDTH-1:0] CMD_DIV = 3'd3;
	localparam logic [CMD_WIDTH-1:0] CMD_POW = 3'd4;
	localparam logic [CMD_WIDTH-1:0] CMD_NEG = 3'd5;

	// Datapath operations requested by the controller.
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LOAD     = 4'd1;  // capture operands, start reducing a and b
	localparam logic [3:0] OP_RED_STEP = 4'd2;  // one bit of reduction of a and b
	localparam logic [3:0] OP_SIMPLE   = 4'd3;  // add, sub, neg, invalid into result
	localparam logic [3:0] OP_MUL_INIT = 4'd4;  // start multiply x*y
	localparam logic [3:0] OP_MUL_STEP = 4'd5;  // one bit of the multiply
	localparam logic [3:0] OP_EUC_INIT = 4'd6;
	localparam logic [3:0] OP_EUC_STEP = 4'd7;
	localparam logic [3:0] OP_EUC_FIN  = 4'd8;
	localparam logic [3:0] OP_POW_INIT = 4'd9;
	localparam logic [3:0] OP_MUL_DONE = 4'd10; // write product to its target

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] mul_sel;  // multiply operand/target selection
	} mau_cmd_t;

	localparam logic [1:0] MSEL_AB   = 2'd0;  // res = a*b
	localparam logic [1:0] MSEL_AINV = 2'd1;  // res = a*inv
	localparam logic [1:0] MSEL_RB   = 2'd2;  // res = res*base
	localparam logic [1:0] MSEL_BB   = 2'd3;  // base = base*base

	typedef struct packed {
		logic red_done;
		logic mul_done;
		logic euc_done;
		logic exp_zero;
		logic exp_bit;
		logic mod_zero;
	} mau_sts_t;
endpackage

>>> sv/mau_if.sv
// ----------------------------------------------------------------------------
// mau_in_if / mau_out_if
// Valid/ready channels carrying the input word and the result word.
// ----------------------------------------------------------------------------
interface mau_in_if;
	import mau_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CMD_WIDTH-1:0] command;
	logic [MOD_WIDTH-1:0] operand_a;
	logic [MOD_WIDTH-1:0] operand_b;
	logic [EXP_WIDTH-1:0] exponent;
	modport source (output valid, command, operand_a, operand_b, exponent, input ready);
	modport sink (input valid, command, operand_a, operand_b, exponent, output ready);
endinterface

interface mau_out_if;
	import mau_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [MOD_WIDTH-1:0] result;
	modport source (output valid, result, input ready);
	modport sink (input valid, result, output ready);
endinterface

>>> sv/mau_datapath.sv
// ----------------------------------------------------------------------------
// mau_datapath
// Operand registers, bit-serial reducer and multiplier, Euclid step unit.
// ----------------------------------------------------------------------------
module mau_datapath (
	input  logic                          clk,
	input  mau_pkg::mau_cmd_t             cmd,
	input  logic [mau_pkg::MOD_WIDTH-1:0] modulus,
	input  logic [mau_pkg::MOD_WIDTH-1:0] in_a,
	input  logic [mau_pkg::MOD_WIDTH-1:0] in_b,
	input  logic [mau_pkg::CMD_WIDTH-1:0] in_command,
	input  logic [mau_pkg::EXP_WIDTH-1:0] in_exponent,
	output mau_pkg::mau_sts_t             sts,
	output logic [mau_pkg::MOD_WIDTH-1:0] result
);
	import mau_pkg::*;

	localparam int W = MOD_WIDTH;

	logic [W-1:0]         a_q, b_q, res_q, base_q, inv_q;
	logic [W-1:0]         ra_q, rb_q;      // reduction remainders
	logic [W-1:0]         sa_q, sb_q;      // raw operands being shifted in
	logic [BIT_CNT_WIDTH-1:0] cnt_q;
	logic [EXP_WIDTH-1:0] exp_q;
	logic [CMD_WIDTH-1:0] opc_q;
	// multiplier
	logic [W-1:0]         mx_q, my_q, macc_q;
	// Euclid: the Bezout coefficients never exceed the modulus in magnitude,
	// so one sign bit above the modulus width is enough to hold them.
	logic signed [W+1:0]  ea_q, eb_q;
	logic signed [W+1:0]  eu_q, ev_q;
	// Quotient times ev, built up one quotient bit at a time during the divide.
	logic signed [W+1:0]  pv_q;
	logic signed [W+1:0]  rem_q, div_q;
	logic [W-1:0]         quo_q;
	logic                 div_busy_q;

	// Shift-in of one bit into a remainder with conditional subtract.
	function automatic logic [W-1:0] red_bit(input logic [W-1:0] r, input logic bit_in,
			input logic [W-1:0] m);
		logic [W:0] t;
		t = {r, bit_in};
		if (t >= {1'b0, m}) t = t - {1'b0, m};
		return t[W-1:0];
	endfunction

	// Modular doubling plus optional addend, both below m.
	logic [W:0] dbl, dbl_r, addv, addv_r;
	always_comb begin
		dbl   = {macc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
		addv  = dbl_r + (mx_q[W-1] ? {1'b0, my_q} : '0);
		addv_r = (addv >= {1'b0, modulus}) ? addv - {1'b0, modulus} : addv;
	end

	// Signed long-division step for Euclid quotient (values nonnegative here).
	logic signed [W+2:0] rtry;
	assign rtry = {rem_q[W:0], quo_q[W-1]} - {1'b0, div_q};

	logic [W:0] sum_ab, sub_ab;
	assign sum_ab = {1'b0, a_q} + {1'b0, b_q};
	assign sub_ab = {1'b0, a_q} + {1'b0, modulus} - {1'b0, b_q};

	logic signed [W+1:0] mod_s;
	assign mod_s = signed'({2'b00, modulus});

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				sa_q  <= in_a;
				sb_q  <= in_b;
				ra_q  <= '0;
				rb_q  <= '0;
				cnt_q <= '0;
				exp_q <= in_exponent;
				opc_q <= in_command;
			end
			OP_RED_STEP: begin
				ra_q  <= red_bit(ra_q, sa_q[W-1], modulus);
				rb_q  <= red_bit(rb_q, sb_q[W-1], modulus);
				sa_q  <= {sa_q[W-2:0], 1'b0};
				sb_q  <= {sb_q[W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == BIT_CNT_WIDTH'(W - 1)) begin
					a_q <= red_bit(ra_q, sa_q[W-1], modulus);
					b_q <= red_bit(rb_q, sb_q[W-1], modulus);
				end
			end
			OP_SIMPLE: begin
				case (opc_q)
					CMD_ADD: res_q <= (sum_ab >= {1'b0, modulus}) ?
						W'(sum_ab - {1'b0, modulus}) : W'(sum_ab);
					CMD_SUB: res_q <= (sub_ab >= {1'b0, modulus}) ?
						W'(sub_ab - {1'b0, modulus}) : W'(sub_ab);
					CMD_NEG: res_q <= (a_q == '0) ? '0 : modulus - a_q;
					default: res_q <= '0;
				endcase
			end
			OP_MUL_INIT: begin
				case (cmd.mul_sel)
					MSEL_AB:   begin mx_q <= a_q;   my_q <= b_q;    end
					MSEL_AINV: begin mx_q <= a_q;   my_q <= inv_q;  end
					MSEL_RB:   begin mx_q <= res_q; my_q <= base_q; end
					default:   begin mx_q <= base_q; my_q <= base_q; end
				endcase
				macc_q <= '0;
				cnt_q  <= '0;
			end
			OP_MUL_STEP: begin
				macc_q <= addv_r[W-1:0];
				mx_q   <= {mx_q[W-2:0], 1'b0};
				cnt_q  <= cnt_q + 1'b1;
			end
			OP_MUL_DONE: begin
				if (cmd.mul_sel == MSEL_BB) begin
					base_q <= macc_q;
					exp_q  <= {1'b0, exp_q[EXP_WIDTH-1:1]};
				end else begin
					res_q <= macc_q;
				end
			end
			OP_POW_INIT: begin
				base_q <= a_q;
				res_q  <= (modulus == W'(1)) ? '0 : W'(1);
			end
			OP_EUC_INIT: begin
				ea_q <= (W+2)'(b_q);
				eb_q <= (W+2)'(modulus);
				eu_q <= (W+2)'(1);
				ev_q <= '0;
				div_busy_q <= 1'b0;
			end
			OP_EUC_STEP: begin
				if (!div_busy_q) begin
					if (eb_q != 0) begin
						quo_q <= ea_q[W-1:0];
						rem_q <= '0;
						div_q <= eb_q;
						pv_q  <= '0;
						cnt_q <= '0;
						div_busy_q <= 1'b1;
					end
				end else if (cnt_q != BIT_CNT_WIDTH'(W)) begin
					// Quotient bits arrive most significant first, so the
					// product with ev is accumulated by shift and add.
					if (rtry >= 0) begin
						rem_q <= rtry[W+1:0];
						quo_q <= {quo_q[W-2:0], 1'b1};
						pv_q  <= (pv_q <<< 1) + ev_q;
					end else begin
						rem_q <= {rem_q[W:0], quo_q[W-1]};
						quo_q <= {quo_q[W-2:0], 1'b0};
						pv_q  <= pv_q <<< 1;
					end
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ea_q <= eb_q;
					eb_q <= rem_q;
					eu_q <= ev_q;
					ev_q <= eu_q - pv_q;
					div_busy_q <= 1'b0;
				end
			end
			OP_EUC_FIN: begin
				// The final coefficient lies strictly inside plus or minus the
				// modulus, so one conditional add brings it into range.
				inv_q <= (eu_q < 0) ? W'(eu_q + mod_s) : W'(eu_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.red_done = (cnt_q == BIT_CNT_WIDTH'(W - 1));
		sts.mul_done = (cnt_q == BIT_CNT_WIDTH'(W - 1));
		sts.euc_done = (eb_q == 0) && !div_busy_q;
		sts.exp_zero = (exp_q == '0);
		sts.exp_bit  = exp_q[0];
		sts.mod_zero = (modulus == '0);
	end
	assign result = res_q;
endmodule

>>> sv/mau_ctrl.sv
// ----------------------------------------------------------------------------
// mau_ctrl
// Sequencer: steps the datapath through reduction and the selected command.
// ----------------------------------------------------------------------------
module mau_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mau_pkg::CMD_WIDTH-1:0] in_command,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  mau_pkg::mau_sts_t             sts,
	output mau_pkg::mau_cmd_t             cmd,
	output logic                          zero_out
);
	import mau_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RED  = 4'd1;
	localparam logic [3:0] S_DISP = 4'd2;
	localparam logic [3:0] S_MINI = 4'd3;
	localparam logic [3:0] S_MSTP = 4'd4;
	localparam logic [3:0] S_MDON = 4'd5;
	localparam logic [3:0] S_EINI = 4'd6;
	localparam logic [3:0] S_ESTP = 4'd7;
	localparam logic [3:0] S_EFIN = 4'd8;
	localparam logic [3:0] S_PINI = 4'd9;
	localparam logic [3:0] S_PCHK = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	logic [3:0]           state_q, state_d;
	logic [CMD_WIDTH-1:0] opc_q;
	logic [1:0]           msel_q, msel_d;
	logic                 zero_q, zero_d;

	assign in_ready  = (state_q == S_IDLE) || (state_q == S_DONE && out_ready);
	assign out_valid = (state_q == S_DONE);
	assign zero_out  = zero_q;

	always_comb begin
		state_d = state_q;
		msel_d  = msel_q;
		zero_d  = zero_q;
		cmd.op  = OP_NONE;
		cmd.mul_sel = msel_q;
		case (state_q)
			S_IDLE, S_DONE: begin
				if (in_valid && in_ready) begin
					cmd.op  = OP_LOAD;
					zero_d  = sts.mod_zero;
					state_d = S_RED;
				end else if (state_q == S_DONE && out_ready) begin
					state_d = S_IDLE;
				end
			end
			S_RED: begin
				cmd.op = OP_RED_STEP;
				if (sts.red_done) state_d = S_DISP;
			end
			S_DISP: begin
				if (zero_q) begin
					state_d = S_DONE;
				end else begin
					case (opc_q)
						CMD_MUL: begin msel_d = MSEL_AB; state_d = S_MINI; end
						CMD_DIV: state_d = S_EINI;
						CMD_POW: state_d = S_PINI;
						default: begin cmd.op = OP_SIMPLE; state_d = S_DONE; end
					endcase
				end
			end
			S_MINI: begin
				cmd.op  = OP_MUL_INIT;
				state_d = S_MSTP;
			end
			S_MSTP: begin
				cmd.op = OP_MUL_STEP;
				if (sts.mul_done) state_d = S_MDON;
			end
			S_MDON: begin
				cmd.op = OP_MUL_DONE;
				if (opc_q == CMD_POW) begin
					if (msel_q == MSEL_RB) begin
						msel_d  = MSEL_BB;
						state_d = S_MINI;
					end else begin
						state_d = S_PCHK;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_EINI: begin
				cmd.op  = OP_EUC_INIT;
				state_d = S_ESTP;
			end
			S_ESTP: begin
				cmd.op = OP_EUC_STEP;
				if (sts.euc_done) state_d = S_EFIN;
			end
			S_EFIN: begin
				cmd.op  = OP_EUC_FIN;
				msel_d  = MSEL_AINV;
				state_d = S_MINI;
			end
			S_PINI: begin
				cmd.op  = OP_POW_INIT;
				state_d = S_PCHK;
			end
			S_PCHK: begin
				if (sts.exp_zero) begin
					state_d = S_DONE;
				end else begin
					msel_d  = sts.exp_bit ? MSEL_RB : MSEL_BB;
					state_d = S_MINI;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			msel_q  <= MSEL_AB;
			zero_q  <= 1'b0;
			opc_q   <= CMD_ADD;
		end else begin
			state_q <= state_d;
			msel_q  <= msel_d;
			zero_q  <= zero_d;
			if (cmd.op == OP_LOAD) opc_q <= in_command;
		end
	end
endmodule

>>> sv/modular_arith_unit.sv
// ----------------------------------------------------------------------------
// modular_arith_unit
// Modular add, subtract, multiply, divide, power and negate over a
// programmable modulus.
// ----------------------------------------------------------------------------
// One word is worked on at a time. Both operands are first reduced bit
// serially. Add, subtract and negate then finish in the dispatch step. A
// multiply is a shift-and-add loop. Divide runs the extended Euclidean
// algorithm with a serial divider, roughly 45 quotients at most, followed
// by one multiply. Power runs up to 64 rounds of one or two multiplies.
// The result word stays valid until it is taken, and the next input word
// is accepted in the same cycle. A modulus of zero makes every result
// zero. The modulus register may be written only while no word is in
// flight.
module modular_arith_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mau_pkg::MOD_WIDTH-1:0] cfg_wdata,
	mau_in_if.sink                        in_ch,
	mau_out_if.source                     out_ch
);
	import mau_pkg::*;

	logic [MOD_WIDTH-1:0] modulus_q;
	logic [MOD_WIDTH-1:0] dp_result;
	mau_cmd_t             cmd;
	mau_sts_t             sts;
	logic                 zero_res;

	// The modulus register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata;
		end
	end

	mau_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_command (in_ch.command),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.sts        (sts),
		.cmd        (cmd),
		.zero_out   (zero_res)
	);

	mau_datapath u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.modulus     (modulus_q),
		.in_a        (in_ch.operand_a),
		.in_b        (in_ch.operand_b),
		.in_command  (in_ch.command),
		.in_exponent (in_ch.exponent),
		.sts         (sts),
		.result      (dp_result)
	);

	// With a zero modulus the result is forced to zero.
	assign out_ch.result = zero_res ? '0 : dp_result;
endmodule

>>> tb/tb_modular_arith_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_arith_unit
// Drives command words of every kind through the modular arithmetic unit.
// The modulus is swept over several values, from the degenerate ones to the
// largest. Each result word is checked against a predictor of its own.
// ----------------------------------------------------------------------------
module tb_modular_arith_unit;
	import mau_pkg::*;

	// Command codes that the block does not define. They must still answer zero.
	localparam logic [CMD_WIDTH-1:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [CMD_WIDTH-1:0] CMD_UNUSED_HI = 3'd7;
	localparam logic [MOD_WIDTH-1:0] OPERAND_MAX = '1;
	localparam int STALL_LIMIT = 30000;
	localparam int HOLD_OFF_CYCLES = 300;

	// Holds the current modulus, computes the expected result of each accepted
	// word, and checks result words in order.
	class modarith_scoreboard;
		logic [MOD_WIDTH-1:0] modulus;
		logic [MOD_WIDTH-1:0] expected_results[$];
		int errors;

		function new();
			modulus = MODULUS_RESET;
			errors = 0;
		endfunction

		function longint unsigned mul_mod(longint unsigned x, longint unsigned y,
				longint unsigned m);
			return (x * y) % m;
		endfunction

		// Extended Euclid on signed 64-bit values. Division truncates toward
		// zero, and the coefficient is then folded into range.
		function longint unsigned inv_mod(longint unsigned x, longint unsigned m);
			longint ra, rb, cu, cv, q, na, nu, r;
			ra = x;
			rb = m;
			cu = 1;
			cv = 0;
			while (rb != 0) begin
				q = ra / rb;
				na = ra - q * rb;
				nu = cu - q * cv;
				ra = rb;
				rb = na;
				cu = cv;
				cv = nu;
			end
			r = cu % longint'(m);
			if (r < 0)
				r += longint'(m);
			return r;
		endfunction

		// Square-and-multiply, exponent taken from its low bit up.
		function longint unsigned pow_mod(longint unsigned base,
				logic [EXP_WIDTH-1:0] k, longint unsigned m);
			longint unsigned r;
			r = 1 % m;
			while (k != 0) begin
				if (k[0])
					r = mul_mod(r, base, m);
				base = mul_mod(base, base, m);
				k = k >> 1;
			end
			return r;
		endfunction

		function logic [MOD_WIDTH-1:0] modular_result(logic [CMD_WIDTH-1:0] cmd,
				logic [MOD_WIDTH-1:0] a, logic [MOD_WIDTH-1:0] b,
				logic [EXP_WIDTH-1:0] e);
			longint unsigned m, ra, rb, r;
			if (modulus == 0)
				return '0;
			m = modulus;
			ra = a % m;
			rb = b % m;
			case (cmd)
				CMD_ADD: r = (ra + rb) % m;
				CMD_SUB: r = (ra + m - rb) % m;
				CMD_MUL: r = mul_mod(ra, rb, m);
				CMD_DIV: r = mul_mod(ra, inv_mod(rb, m), m);
				CMD_POW: r = pow_mod(ra, e, m);
				CMD_NEG: r = (ra == 0) ? 0 : m - ra;
				default: r = 0;
			endcase
			return MOD_WIDTH'(r);
		endfunction

		function void note_word(logic [CMD_WIDTH-1:0] cmd, logic [MOD_WIDTH-1:0] a,
				logic [MOD_WIDTH-1:0] b, logic [EXP_WIDTH-1:0] e);
			expected_results.push_back(modular_result(cmd, a, b, e));
		endfunction

		function void check_result(logic [MOD_WIDTH-1:0] actual);
			logic [MOD_WIDTH-1:0] want;
			if (expected_results.size() == 0) begin
				$error("result word 0x%0h arrived with nothing expected", actual);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (actual !== want) begin
				$error("field result: expected %0d, actual %0d", want, actual);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [MOD_WIDTH-1:0] cfg_wdata;

	mau_in_if in_ch ();
	mau_out_if out_ch ();

	modular_arith_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	modarith_scoreboard sb;
	bit idle_en;       // random gaps on both sides while set
	bit hold_request;  // asks the receiver for one long hold-off
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.command = '0;
		in_ch.operand_a = '0;
		in_ch.operand_b = '0;
		in_ch.exponent = '0;
		out_ch.ready = 1'b0;
		idle_en = 1'b1;
		hold_request = 1'b0;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: random stalls, plus one long hold-off counted here so the
	// sender keeps offering words and the block backs up onto its input.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	// Both handshakes are sampled at the edge, before any driver updates land.
	// The watchdog counts cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_word(in_ch.command, in_ch.operand_a, in_ch.operand_b,
					in_ch.exponent);
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.result);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Offers one word and returns at the edge where it is taken. Valid stays
	// high so that a following word can go out back to back.
	task automatic send_word(logic [CMD_WIDTH-1:0] cmd, logic [MOD_WIDTH-1:0] a,
			logic [MOD_WIDTH-1:0] b, logic [EXP_WIDTH-1:0] e);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.operand_a <= a;
		in_ch.operand_b <= b;
		in_ch.exponent <= e;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Lets the block drain before the modulus changes under it.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_modulus(logic [MOD_WIDTH-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.modulus = value;
		@(posedge clk);
	endtask

	function automatic logic [MOD_WIDTH-1:0] random_operand();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return OPERAND_MAX;
			2: return sb.modulus;
			3: return MOD_WIDTH'($urandom_range(0, 15));
			default: return MOD_WIDTH'($urandom);
		endcase
	endfunction

	// Power dominates the run time, so it is picked less often than add, multiply and divide.
	task automatic send_random_words(int count);
		logic [CMD_WIDTH-1:0] cmd;
		logic [EXP_WIDTH-1:0] e;
		repeat (count) begin
			case ($urandom_range(0, 15))
				0, 1, 2: cmd = CMD_ADD;
				3, 4: cmd = CMD_SUB;
				5, 6, 7: cmd = CMD_MUL;
				8, 9, 10: cmd = CMD_DIV;
				11, 12: cmd = CMD_POW;
				13: cmd = CMD_NEG;
				14: cmd = CMD_UNUSED_LO;
				default: cmd = CMD_UNUSED_HI;
			endcase
			e = {$urandom, $urandom};
			if ($urandom_range(0, 2) == 0)
				e = EXP_WIDTH'($urandom_range(0, 40));
			send_word(cmd, random_operand(), random_operand(), e);
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);

		// Directed words under the reset modulus: operand extremes, operands
		// equal to the modulus, divide by zero, the zero exponent and the
		// undefined command codes.
		send_word(CMD_ADD, OPERAND_MAX, OPERAND_MAX, '0);
		send_word(CMD_ADD, MOD_WIDTH'(sb.modulus - 1), 1, '0);
		send_word(CMD_SUB, '0, OPERAND_MAX, '0);
		send_word(CMD_SUB, 5, 5, '0);
		send_word(CMD_MUL, OPERAND_MAX, OPERAND_MAX, '0);
		send_word(CMD_MUL, sb.modulus, 12345, '0);
		send_word(CMD_DIV, 7, '0, '0);
		send_word(CMD_DIV, 7, sb.modulus, '0);
		send_word(CMD_DIV, OPERAND_MAX, 3, '0);
		send_word(CMD_DIV, 1, MOD_WIDTH'(sb.modulus - 1), '0);
		send_word(CMD_POW, 2, 0, '0);
		send_word(CMD_POW, '0, 0, '0);
		send_word(CMD_POW, OPERAND_MAX, 0, '1);
		send_word(CMD_POW, 3, 0, 64'h8000_0000_0000_0000);
		send_word(CMD_POW, '0, 0, 64'd5);
		send_word(CMD_NEG, '0, OPERAND_MAX, '0);
		send_word(CMD_NEG, OPERAND_MAX, 0, '0);
		send_word(CMD_NEG, sb.modulus, 0, '0);
		send_word(CMD_UNUSED_LO, OPERAND_MAX, OPERAND_MAX, '1);
		send_word(CMD_UNUSED_HI, 9, 9, 64'd3);
		send_random_words(25);

		// Largest modulus, with the long receiver hold-off in the middle.
		write_modulus(OPERAND_MAX);
		send_random_words(8);
		hold_request = 1'b1;
		send_random_words(15);

		// Smallest useful modulus, then the degenerate ones.
		write_modulus(2);
		send_random_words(10);
		write_modulus(1);
		send_random_words(6);
		write_modulus('0);
		send_random_words(6);

		// A small prime, then a composite where divisors need not be coprime.
		write_modulus(65537);
		send_random_words(14);
		write_modulus(1000000);
		send_word(CMD_DIV, 3, 250000, '0);
		send_random_words(14);

		// Last stretch at the default value, with no gaps on either side.
		write_modulus(MODULUS_RESET);
		idle_en = 1'b0;
		send_random_words(20);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

>>> filelist.f
sv/mau_pkg.sv
sv/mau_if.sv
sv/mau_datapath.sv
sv/mau_ctrl.sv
sv/modular_arith_unit.sv
tb/tb_modular_arith_unit.sv
